// File: hdl/process_capability_table_assert.svh
// assertion macros for the process capability table
// expects clk and rst_n in the scope of the module that uses them
`ifndef PROCESS_CAPABILITY_TABLE_ASSERT_SVH
`define PROCESS_CAPABILITY_TABLE_ASSERT_SVH

// condition holds in the same cycle
`define PCT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the cycle after the antecedent
`define PCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/pct_pkg.sv
// shared types and constants for the process capability table
// no dependencies
`default_nettype none

package pct_pkg;

  localparam int KEY_W  = 32;
  localparam int MASK_W = 64;

  localparam logic [KEY_W-1:0]  ROOT_ID   = 32'd1;
  localparam logic [MASK_W-1:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [6:0]        CAP_COUNT = 7'd41;

  typedef enum logic [2:0] {
    OP_GET     = 3'd0,
    OP_SET     = 3'd1,
    OP_CAPABLE = 3'd2,
    OP_DROP    = 3'd3,
    OP_RAISE   = 3'd4,
    OP_EXEC    = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_INVAL = 2'd1,
    ST_PERM  = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic [MASK_W-1:0] eff;
    logic [MASK_W-1:0] perm;
    logic [MASK_W-1:0] inh;
    logic [MASK_W-1:0] bnd;
    logic [MASK_W-1:0] amb;
  } mask_set_t;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [KEY_W-1:0] process_id;
    logic [5:0]       cap_index;
    mask_set_t        new_masks;
  } req_t;

  // outcome of the key scan
  typedef struct packed {
    logic hit;
    logic alloc;
    logic full;
  } lookup_t;

  typedef struct packed {
    status_t   status;
    logic      is_capable;
    mask_set_t masks;
  } result_t;

  localparam mask_set_t ROOT_MASKS = '{eff: ALL_ONES, perm: ALL_ONES, inh: ALL_ONES,
                                       bnd: ALL_ONES, amb: '0};
  localparam mask_set_t GET_NEW_MASKS = '{eff: '0, perm: '0, inh: '0,
                                          bnd: ALL_ONES, amb: '0};

endpackage

`default_nettype wire

// File: hdl/pct_ifs.sv
// valid/ready channel interfaces for request and result beats
// depends on pct_pkg for field widths
`default_nettype none

interface pct_in_if;
  import pct_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        opcode;
  logic [KEY_W-1:0]  process_id;
  logic [5:0]        cap_index;
  logic [MASK_W-1:0] set_effective;
  logic [MASK_W-1:0] set_permitted;
  logic [MASK_W-1:0] set_inheritable;
  logic [MASK_W-1:0] set_bounding;
  logic [MASK_W-1:0] set_ambient;

  modport source (output valid, opcode, process_id, cap_index, set_effective,
                  set_permitted, set_inheritable, set_bounding, set_ambient,
                  input ready);
  modport sink (input valid, opcode, process_id, cap_index, set_effective,
                set_permitted, set_inheritable, set_bounding, set_ambient,
                output ready);
endinterface

interface pct_out_if;
  import pct_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic              is_capable;
  logic [MASK_W-1:0] cur_effective;
  logic [MASK_W-1:0] cur_permitted;
  logic [MASK_W-1:0] cur_inheritable;
  logic [MASK_W-1:0] cur_bounding;
  logic [MASK_W-1:0] cur_ambient;

  modport source (output valid, status, is_capable, cur_effective, cur_permitted,
                  cur_inheritable, cur_bounding, cur_ambient, input ready);
  modport sink (input valid, status, is_capable, cur_effective, cur_permitted,
                cur_inheritable, cur_bounding, cur_ambient, output ready);
endinterface

`default_nettype wire

// File: hdl/process_capability_table.sv
// process capability table: associative table of capability mask sets
// request beats on in_chan, one result beat per request on out_chan.
// keys live in a key memory that is scanned one entry a cycle from entry 0;
// the five masks of the matched entry are read from a mask memory, updated
// and written back in the execute state.
// entries are never freed, so the valid entries are always 0 .. fill-1 and
// a fill count replaces any per-entry valid bit; allocation takes slot fill.
// timing: a request that hits slot k scans entries 0 .. k, a request that
// misses scans all fill entries (fill = allocated entries, at most
// ENTRIES); the key memory read port, one entry per cycle, sets the scan
// length. the result beat is registered and follows the execute state.
// one request is in flight at a time; in_chan.ready is high when idle.
// a result waiting on a stalled out_chan does not block acceptance of the
// next request, but that request's execute cycle waits until the output
// register is free.
// reset: synchronous, active low; afterwards entry 0 holds id 1 with full
// masks (ambient zero). no memory clearing pass is needed.
`default_nettype none

module process_capability_table #(
  parameter int ENTRIES = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  pct_in_if.sink       in_chan,
  pct_out_if.source    out_chan
);
  import pct_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FILL_MAX = CW'(ENTRIES);

  state_t         state_r, state_nxt;
  req_t           req_r, req_nxt;
  logic [IW-1:0]  idx_r, idx_nxt;
  logic [IW-1:0]  rd_idx_r, rd_idx_nxt;
  logic [IW-1:0]  slot_r, slot_nxt;
  lookup_t        lk_r, lk_nxt;
  logic [CW-1:0]  fill_r, fill_nxt;
  logic           out_valid_r, out_valid_nxt;
  result_t        res_r, res_nxt;

  logic           in_acc;
  logic           in_ready;
  logic           exec_go;
  logic           key_re;
  logic [IW-1:0]  key_raddr;
  logic           key_hit;
  logic           mask_re;
  logic [IW-1:0]  mask_raddr;
  mask_set_t      mask_rd;
  mask_set_t      base;
  result_t        op_res;
  logic           op_we;
  mask_set_t      op_wmasks;
  logic           is_get_set;

  assign in_chan.ready = in_ready;
  assign in_acc        = in_chan.valid && in_ready;
  assign is_get_set    = (req_r.opcode == OP_GET) || (req_r.opcode == OP_SET);

  pct_key_store #(.ENTRIES(ENTRIES)) u_keys (
    .clk     (clk),
    .rd_en   (key_re),
    .rd_addr (key_raddr),
    .wr_en   (exec_go && lk_r.alloc),
    .wr_addr (slot_r),
    .wr_key  (req_r.process_id),
    .cmp_key (req_r.process_id),
    .hit     (key_hit)
  );

  pct_mask_store #(.ENTRIES(ENTRIES)) u_masks (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (mask_re),
    .rd_addr  (mask_raddr),
    .wr_en    (exec_go && op_we),
    .wr_addr  (slot_r),
    .wr_masks (op_wmasks),
    .rd_masks (mask_rd)
  );

  // masks before the step; a fresh entry starts from its default set
  always_comb begin
    if (lk_r.hit) begin
      base = mask_rd;
    end else if (req_r.opcode == OP_GET) begin
      base = GET_NEW_MASKS;
    end else begin
      base = '0;
    end
  end

  pct_op_unit u_op (
    .req      (req_r),
    .lk       (lk_r),
    .base     (base),
    .res      (op_res),
    .wr_en    (op_we),
    .wr_masks (op_wmasks)
  );

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    idx_nxt       = idx_r;
    rd_idx_nxt    = rd_idx_r;
    slot_nxt      = slot_r;
    lk_nxt        = lk_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    res_nxt       = res_r;
    in_ready      = 1'b0;
    exec_go       = 1'b0;
    key_re        = 1'b0;
    key_raddr     = idx_r;
    mask_re       = 1'b0;
    mask_raddr    = rd_idx_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_chan.valid) begin
          req_nxt.opcode             = in_chan.opcode;
          req_nxt.process_id         = in_chan.process_id;
          req_nxt.cap_index          = in_chan.cap_index;
          req_nxt.new_masks.eff      = in_chan.set_effective;
          req_nxt.new_masks.perm     = in_chan.set_permitted;
          req_nxt.new_masks.inh      = in_chan.set_inheritable;
          req_nxt.new_masks.bnd      = in_chan.set_bounding;
          req_nxt.new_masks.amb      = in_chan.set_ambient;
          key_re     = 1'b1;
          key_raddr  = '0;
          rd_idx_nxt = '0;
          idx_nxt    = IW'(1);
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (key_hit) begin
          lk_nxt     = '{hit: 1'b1, alloc: 1'b0, full: 1'b0};
          slot_nxt   = rd_idx_r;
          mask_re    = 1'b1;
          mask_raddr = rd_idx_r;
          state_nxt  = S_EXEC;
        end else if ((CW'(rd_idx_r) + CW'(1)) == fill_r) begin
          // last valid entry checked without a match
          lk_nxt.hit   = 1'b0;
          lk_nxt.alloc = is_get_set && (fill_r != FILL_MAX);
          lk_nxt.full  = is_get_set && (fill_r == FILL_MAX);
          slot_nxt     = fill_r[IW-1:0];
          state_nxt    = S_EXEC;
        end else begin
          key_re     = 1'b1;
          key_raddr  = idx_r;
          rd_idx_nxt = idx_r;
          idx_nxt    = idx_r + IW'(1);
        end
      end
      S_EXEC: begin
        if (!out_valid_r || out_chan.ready) begin
          exec_go       = 1'b1;
          out_valid_nxt = 1'b1;
          res_nxt       = op_res;
          if (lk_r.alloc) begin
            fill_nxt = fill_r + CW'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= CW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    idx_r    <= idx_nxt;
    rd_idx_r <= rd_idx_nxt;
    slot_r   <= slot_nxt;
    lk_r     <= lk_nxt;
    res_r    <= res_nxt;
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.status          = res_r.status;
  assign out_chan.is_capable      = res_r.is_capable;
  assign out_chan.cur_effective   = res_r.masks.eff;
  assign out_chan.cur_permitted   = res_r.masks.perm;
  assign out_chan.cur_inheritable = res_r.masks.inh;
  assign out_chan.cur_bounding    = res_r.masks.bnd;
  assign out_chan.cur_ambient     = res_r.masks.amb;

`include "process_capability_table_assert.svh"

  `PCT_ASSERT_NEXT(a_accept_starts_scan, in_acc, state_r == S_SCAN, "accept did not start a scan")
  `PCT_ASSERT_NEXT(a_alloc_bumps_fill, exec_go && lk_r.alloc, fill_r == $past(fill_r) + 1'b1, "fill count did not follow allocation")
  `PCT_ASSERT_SAME(a_full_only_at_cap, state_r == S_EXEC && lk_r.full, fill_r == FILL_MAX, "table full reported below capacity")
  `PCT_ASSERT_SAME(a_result_from_exec, $rose(out_valid_r), $past(state_r) == S_EXEC, "result beat raised outside execute")

endmodule

`default_nettype wire

// File: hdl/pct_key_store.sv
// key memory with registered read and key compare on the read data
// depends on pct_pkg; entry zero always carries the root id
`default_nettype none

module pct_key_store #(
  parameter int  ENTRIES = 32,
  localparam int IW      = $clog2(ENTRIES)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  logic [31:0]   wr_key,
  input  logic [31:0]   cmp_key,
  output logic          hit
);
  import pct_pkg::*;

  logic [KEY_W-1:0] mem [ENTRIES];
  logic [KEY_W-1:0] q_r;
  logic             zero_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_key;
    end
    if (rd_en) begin
      q_r    <= mem[rd_addr];
      zero_r <= (rd_addr == '0);
    end
  end

  // entry zero is never allocated, its key is fixed
  assign hit = zero_r ? (cmp_key == ROOT_ID) : (q_r == cmp_key);

endmodule

`default_nettype wire

// File: hdl/pct_mask_store.sv
// mask memory holding the five capability masks of every entry
// depends on pct_pkg; entry zero reads its reset masks until first written
`default_nettype none

module pct_mask_store #(
  parameter int  ENTRIES = 32,
  localparam int IW      = $clog2(ENTRIES)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rd_en,
  input  logic [IW-1:0]      rd_addr,
  input  logic               wr_en,
  input  logic [IW-1:0]      wr_addr,
  input  pct_pkg::mask_set_t wr_masks,
  output pct_pkg::mask_set_t rd_masks
);
  import pct_pkg::*;

  mask_set_t mem [ENTRIES];
  mask_set_t q_r;
  logic      zero_r;
  logic      root_init_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_masks;
    end
    if (rd_en) begin
      q_r    <= mem[rd_addr];
      zero_r <= (rd_addr == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_init_r <= 1'b1;
    end else if (wr_en && wr_addr == '0) begin
      root_init_r <= 1'b0;
    end
  end

  assign rd_masks = (zero_r && root_init_r) ? ROOT_MASKS : q_r;

endmodule

`default_nettype wire

// File: hdl/pct_op_unit.sv
// opcode decode, subset checks and mask update for one request
// depends on pct_pkg; purely combinational
`default_nettype none

module pct_op_unit (
  input  pct_pkg::req_t      req,
  input  pct_pkg::lookup_t   lk,
  input  pct_pkg::mask_set_t base,
  output pct_pkg::result_t   res,
  output logic               wr_en,
  output pct_pkg::mask_set_t wr_masks
);
  import pct_pkg::*;

  logic              exists;
  logic              cap_ok;
  logic [MASK_W-1:0] cbit;
  mask_set_t         nm;
  mask_set_t         rq;
  status_t           st;
  logic              capable;

  assign exists = lk.hit || lk.alloc;
  assign cap_ok = {1'b0, req.cap_index} < CAP_COUNT;
  assign cbit   = {{(MASK_W-1){1'b0}}, 1'b1} << req.cap_index;
  assign rq     = req.new_masks;

  always_comb begin
    nm      = base;
    st      = ST_OK;
    capable = 1'b0;
    if (!exists) begin
      st = lk.full ? ST_FULL : ST_INVAL;
    end else begin
      case (req.opcode)
        OP_GET: begin
          st = ST_OK;
        end
        OP_SET: begin
          // subset rules, first failure wins
          if ((rq.perm & ~base.perm) != '0) begin
            st = ST_PERM;
          end else if ((rq.eff & ~rq.perm) != '0) begin
            st = ST_INVAL;
          end else if ((rq.inh & ~(rq.perm & base.bnd)) != '0) begin
            st = ST_PERM;
          end else if ((rq.bnd & ~base.bnd) != '0) begin
            st = ST_PERM;
          end else begin
            nm = rq;
          end
        end
        OP_CAPABLE: begin
          if (!cap_ok) begin
            st = ST_INVAL;
          end else begin
            capable = |(base.eff & cbit);
          end
        end
        OP_DROP: begin
          if (!cap_ok) begin
            st = ST_INVAL;
          end else begin
            nm.eff  = base.eff & ~cbit;
            nm.perm = base.perm & ~cbit;
            nm.inh  = base.inh & ~cbit;
            nm.bnd  = base.bnd & ~cbit;
            nm.amb  = base.amb & ~cbit;
          end
        end
        OP_RAISE: begin
          if (!cap_ok) begin
            st = ST_INVAL;
          end else if ((base.perm & cbit) == '0) begin
            st = ST_PERM;
          end else begin
            nm.eff = base.eff | cbit;
          end
        end
        OP_EXEC: begin
          nm.perm = base.inh & base.bnd;
          nm.eff  = base.amb;
        end
        default: begin
          st = ST_INVAL;
        end
      endcase
    end
  end

  // write back whenever an entry exists, unchanged masks included
  assign wr_en          = exists;
  assign wr_masks       = nm;
  assign res.status     = st;
  assign res.is_capable = capable;
  assign res.masks      = exists ? nm : '0;

endmodule

`default_nettype wire

// File: verif/tb.sv
// testbench for the process capability table: directed and random request beats,
// each result checked against an in-bench table predictor
// depends on pct_pkg, pct_ifs and process_capability_table from hdl
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pct_pkg::*;

  localparam int ENTRIES      = 32;
  localparam int POOL_SIZE    = 28;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 40;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  logic clk = 1'b0;
  logic rst_n;

  pct_in_if  in_bus ();
  pct_out_if out_bus ();

  process_capability_table #(.ENTRIES(ENTRIES)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predicted table contents
  bit               tbl_valid [ENTRIES];
  logic [KEY_W-1:0] tbl_key   [ENTRIES];
  mask_set_t        tbl_masks [ENTRIES];

  result_t          expected_results [$];
  logic [KEY_W-1:0] id_pool [POOL_SIZE];
  int unsigned      error_count = 0;
  int unsigned      idle_cycles = 0;
  bit               steady = 1'b0;

  function automatic void reset_table();
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i]   = '0;
      tbl_masks[i] = '0;
    end
    tbl_valid[0] = 1'b1;
    tbl_key[0]   = ROOT_ID;
    tbl_masks[0] = ROOT_MASKS;
  endfunction

  function automatic int find_slot(logic [KEY_W-1:0] id);
    for (int i = 0; i < ENTRIES; i++)
      if (tbl_valid[i] && tbl_key[i] == id) return i;
    return -1;
  endfunction

  function automatic int claim_slot(logic [KEY_W-1:0] id);
    for (int i = 0; i < ENTRIES; i++) begin
      if (!tbl_valid[i]) begin
        tbl_valid[i] = 1'b1;
        tbl_key[i]   = id;
        tbl_masks[i] = '0;
        return i;
      end
    end
    return -1;
  endfunction

  function automatic mask_set_t held_masks(logic [KEY_W-1:0] id);
    int slot;
    slot = find_slot(id);
    return (slot < 0) ? mask_set_t'('0) : tbl_masks[slot];
  endfunction

  // applies one request to the predicted table and returns the result beat
  function automatic result_t apply_request(req_t rq);
    int                slot;
    result_t           res;
    logic [MASK_W-1:0] cap_bit;
    bit                cap_ok;
    mask_set_t         nm;
    mask_set_t         cur;
    slot       = find_slot(rq.process_id);
    res        = '0;
    res.status = ST_OK;
    cap_bit    = 64'd1 << rq.cap_index;
    cap_ok     = rq.cap_index < CAP_COUNT;
    nm         = rq.new_masks;
    case (rq.opcode)
      OP_GET: begin
        if (slot < 0) begin
          slot = claim_slot(rq.process_id);
          if (slot < 0) res.status = ST_FULL;
          else tbl_masks[slot].bnd = ALL_ONES;
        end
      end
      OP_SET: begin
        if (slot < 0) slot = claim_slot(rq.process_id);
        if (slot < 0) begin
          res.status = ST_FULL;
        end else begin
          cur = tbl_masks[slot];
          // subset rules, first failure wins
          if ((nm.perm & ~cur.perm) != '0) res.status = ST_PERM;
          else if ((nm.eff & ~nm.perm) != '0) res.status = ST_INVAL;
          else if ((nm.inh & ~(nm.perm & cur.bnd)) != '0) res.status = ST_PERM;
          else if ((nm.bnd & ~cur.bnd) != '0) res.status = ST_PERM;
          else tbl_masks[slot] = nm;
        end
      end
      OP_CAPABLE: begin
        if (!cap_ok || slot < 0) res.status = ST_INVAL;
        else res.is_capable = (tbl_masks[slot].eff & cap_bit) != '0;
      end
      OP_DROP: begin
        if (!cap_ok || slot < 0) res.status = ST_INVAL;
        else tbl_masks[slot] = tbl_masks[slot] & {5{~cap_bit}};
      end
      OP_RAISE: begin
        if (!cap_ok || slot < 0) res.status = ST_INVAL;
        else if ((tbl_masks[slot].perm & cap_bit) == '0) res.status = ST_PERM;
        else tbl_masks[slot].eff = tbl_masks[slot].eff | cap_bit;
      end
      OP_EXEC: begin
        if (slot < 0) begin
          res.status = ST_INVAL;
        end else begin
          tbl_masks[slot].perm = tbl_masks[slot].inh & tbl_masks[slot].bnd;
          tbl_masks[slot].eff  = tbl_masks[slot].amb;
        end
      end
      default: res.status = ST_INVAL;
    endcase
    if (slot >= 0) res.masks = tbl_masks[slot];
    return res;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] dense_bits();
    return rand64() | rand64() | rand64();
  endfunction

  task automatic send_request(input logic [2:0] op, input logic [KEY_W-1:0] id,
                              input logic [5:0] cap = '0, input mask_set_t m = '0);
    req_t rq;
    int   gap;
    rq.opcode     = op;
    rq.process_id = id;
    rq.cap_index  = cap;
    rq.new_masks  = m;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid           <= 1'b1;
    in_bus.opcode          <= op;
    in_bus.process_id      <= id;
    in_bus.cap_index       <= cap;
    in_bus.set_effective   <= m.eff;
    in_bus.set_permitted   <= m.perm;
    in_bus.set_inheritable <= m.inh;
    in_bus.set_bounding    <= m.bnd;
    in_bus.set_ambient     <= m.amb;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    expected_results.push_back(apply_request(rq));
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  task automatic check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: result beat with nothing expected: expected none, actual status %0d",
               $time, out_bus.status);
      error_count++;
    end else begin
      want = expected_results.pop_front();
      compare_field("status", 64'(want.status), 64'(out_bus.status));
      compare_field("is_capable", 64'(want.is_capable), 64'(out_bus.is_capable));
      compare_field("cur_effective", want.masks.eff, out_bus.cur_effective);
      compare_field("cur_permitted", want.masks.perm, out_bus.cur_permitted);
      compare_field("cur_inheritable", want.masks.inh, out_bus.cur_inheritable);
      compare_field("cur_bounding", want.masks.bnd, out_bus.cur_bounding);
      compare_field("cur_ambient", want.masks.amb, out_bus.cur_ambient);
    end
  endtask

  // result side: checks each beat and stalls ready at random
  initial begin
    int stall;
    stall = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) check_result();
      if (stall > 0) begin
        stall--;
        out_bus.ready <= 1'b0;
      end else begin
        stall = pick_gap();
        out_bus.ready <= (stall == 0);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic test_root_entry();
    send_request(OP_GET, ROOT_ID);
    send_request(OP_CAPABLE, ROOT_ID, 6'd0);
    send_request(OP_CAPABLE, ROOT_ID, 6'd40);
    // indexes past the last capability are rejected
    send_request(OP_CAPABLE, ROOT_ID, 6'd41);
    send_request(OP_CAPABLE, ROOT_ID, 6'd63);
  endtask

  task automatic test_absent_entry();
    // no allocation for these on a missing id
    send_request(OP_CAPABLE, 32'd0, 6'd3);
    send_request(OP_DROP, 32'd0, 6'd3);
    send_request(OP_RAISE, 32'd0, 6'd3);
    send_request(OP_EXEC, 32'd0);
    send_request(OP_SPARE_6, ROOT_ID);
    send_request(OP_SPARE_7, 32'd0);
  endtask

  task automatic test_get_set();
    send_request(OP_GET, 32'd0);
    send_request(OP_SET, 32'hFFFF_FFFF);
    send_request(OP_SET, 32'hFFFF_FFFF, 6'd0, '{eff: '0, perm: '0, inh: '0,
                                               bnd: 64'd1, amb: '0});
    // absent id, failing set still leaves the new entry behind
    send_request(OP_SET, 32'd5, 6'd0, '{eff: '0, perm: 64'd1, inh: '0, bnd: '0, amb: '0});
    send_request(OP_SET, ROOT_ID, 6'd0, '{eff: ALL_ONES, perm: 64'h0F, inh: '0,
                                         bnd: ALL_ONES, amb: '0});
    send_request(OP_SET, ROOT_ID, 6'd0, '{eff: '0, perm: 64'hFF, inh: 64'h100,
                                         bnd: ALL_ONES, amb: '0});
    send_request(OP_SET, ROOT_ID, 6'd0, '{eff: 64'h0000_00F0_0F00_FF0F,
                                         perm: 64'h00FF_FFFF_FFFF_FFFF,
                                         inh: 64'h00FF_0000_FFFF_0000,
                                         bnd: 64'h7FFF_FFFF_FFFF_FFFF,
                                         amb: 64'hA5A5_0000_0000_5A5A});
  endtask

  task automatic test_mask_ops();
    send_request(OP_RAISE, ROOT_ID, 6'd2);
    send_request(OP_DROP, ROOT_ID, 6'd2);
    send_request(OP_RAISE, ROOT_ID, 6'd2);
    send_request(OP_RAISE, ROOT_ID, 6'd63);
    send_request(OP_DROP, ROOT_ID, 6'd50);
    send_request(OP_EXEC, ROOT_ID);
    send_request(OP_CAPABLE, ROOT_ID, 6'd1);
  endtask

  task automatic run_random(input int count);
    int               r;
    logic [2:0]       op;
    logic [KEY_W-1:0] id;
    logic [5:0]       cap;
    mask_set_t        held;
    mask_set_t        m;
    for (int n = 0; n < count; n++) begin
      steady = (n % 300) < 40;
      r = $urandom_range(0, 99);
      if (r < 25) id = ROOT_ID;
      else if (r < 98) id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
      else id = $urandom;
      r = $urandom_range(0, 99);
      if (r < 14) op = OP_GET;
      else if (r < 38) op = OP_SET;
      else if (r < 56) op = OP_CAPABLE;
      else if (r < 61) op = OP_DROP;
      else if (r < 78) op = OP_RAISE;
      else if (r < 94) op = OP_EXEC;
      else op = ($urandom_range(0, 1) == 0) ? OP_SPARE_6 : OP_SPARE_7;
      cap = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, 40))
                                         : 6'($urandom_range(41, 63));
      m = '0;
      if (op == OP_SET) begin
        // build a set that obeys the subset rules, then maybe break it
        held   = held_masks(id);
        m.perm = held.perm & ($urandom_range(0, 1) ? ALL_ONES : dense_bits());
        m.eff  = m.perm & dense_bits();
        m.inh  = m.perm & held.bnd & ($urandom_range(0, 1) ? ALL_ONES : dense_bits());
        m.bnd  = held.bnd & ($urandom_range(0, 1) ? ALL_ONES : dense_bits());
        m.amb  = rand64();
        r = $urandom_range(0, 9);
        if (r == 9) m = {rand64(), rand64(), rand64(), rand64(), rand64()};
        else if (r >= 7) m[$urandom_range(0, $bits(mask_set_t) - 1)] ^= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        // unused payload still toggles
        m = {rand64(), rand64(), rand64(), rand64(), rand64()};
      end
      send_request(op, id, cap, m);
    end
    steady = 1'b0;
  endtask

  task automatic test_table_full();
    while (!tbl_valid[ENTRIES-1]) send_request(OP_GET, $urandom);
    send_request(OP_GET, $urandom);
    send_request(OP_SET, $urandom);
    send_request(OP_GET, $urandom);
  endtask

  initial begin
    rst_n                  <= 1'b0;
    in_bus.valid           <= 1'b0;
    in_bus.opcode          <= OP_GET;
    in_bus.process_id      <= '0;
    in_bus.cap_index       <= '0;
    in_bus.set_effective   <= '0;
    in_bus.set_permitted   <= '0;
    in_bus.set_inheritable <= '0;
    in_bus.set_bounding    <= '0;
    in_bus.set_ambient     <= '0;
    reset_table();
    id_pool[0] = 32'd0;
    id_pool[1] = 32'hFFFF_FFFF;
    id_pool[2] = 32'd5;
    for (int i = 3; i < POOL_SIZE; i++) id_pool[i] = $urandom;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_root_entry();
    test_absent_entry();
    test_get_set();
    test_mask_ops();
    run_random(1200);
    test_table_full();
    run_random(800);

    in_bus.valid <= 1'b0;
    while (expected_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
